FILE: rtl/sbcto_pkg.sv
// ----------------------------------------------------------------------------
// sbcto_pkg - shared constants for the symmetric block-cyclic tile owner unit
// Default parameter values, fixed field widths and configuration register
// indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sbcto_pkg;

  // parameter defaults
  localparam int unsigned TILE_INDEX_BITS_DEF = 16;
  localparam int unsigned GRID_DIM_BITS_DEF   = 12;

  // fixed widths
  localparam int unsigned KEY_W      = 32;  // linear key, also widest tile column
  localparam int unsigned GRID_REG_W = 13;  // grid_rows / grid_cols registers
  localparam int unsigned VP_REG_W   = 9;   // vp_rows / vp_cols registers
  localparam int unsigned VP_W       = 16;  // virtual process index
  localparam int unsigned CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VP_ROWS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VP_COLS    = 3'd7;

endpackage

`default_nettype wire

FILE: rtl/sbcto_div.sv
// ----------------------------------------------------------------------------
// sbcto_div - pipelined unsigned restoring divider
// One quotient bit per stage, N stages; takes a new beat every cycle and
// returns quotient and remainder from the last stage. Divisor must be non-zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sbcto_div #(
  parameter int unsigned N = 32,  // dividend width
  parameter int unsigned D = 16   // divisor width
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire logic [N-1:0] dividend_i,
  input  wire logic [D-1:0] divisor_i,
  output logic              valid_o,
  output logic [N-1:0]      quotient_o,
  output logic [D-1:0]      remainder_o
);

  // per stage: dividend bits still to shift out on top, quotient bits in below
  logic [N-1:0] valid_q;
  logic [N-1:0] word_q [N];
  logic [D-1:0] rem_q  [N];
  logic [D-1:0] dvs_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic         vld_in;
    logic [N-1:0] word_in;
    logic [D-1:0] rem_in;
    logic [D-1:0] dvs_in;
    logic [D:0]   trial;
    logic         take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign word_in = dividend_i;
      assign rem_in  = '0;
      assign dvs_in  = divisor_i;
    end else begin : g_next
      assign vld_in  = valid_q[k-1];
      assign word_in = word_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dvs_in  = dvs_q[k-1];
    end

    // bring down the next dividend bit and try the subtraction
    assign trial = {rem_in, word_in[N-1]};
    assign take  = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? D'(trial - {1'b0, dvs_in}) : trial[D-1:0];
      word_q[k] <= {word_in[N-2:0], take};
      dvs_q[k]  <= dvs_in;
    end
  end

  assign valid_o     = valid_q[N-1];
  assign quotient_o  = word_q[N-1];
  assign remainder_o = rem_q[N-1];

endmodule

`default_nettype wire

FILE: rtl/sym_block_cyclic_tile_owner_unit.sv
// ----------------------------------------------------------------------------
// sym_block_cyclic_tile_owner_unit - tile owner lookup, 2D block-cyclic
// Maps a tile, given as relative coordinates or as a linear key, to its
// global coordinates, owning rank and virtual process index, and flags
// tiles in the unstored half of the symmetric matrix.
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+------------------
//   command  | kind_i tile_row_i tile_col_i tile_key_i        | start_i, !busy_o
//   result   | global_row_o global_col_o owner_rank_o         | done_o, 1 cycle
//            | outside_triangle_o vp_index_o                  |
//   config   | cfg_idx_i cfg_data_i                           | cfg_we_i
//
// One beat accepted per cycle; each result passes the input register, three
// chained 32-stage pipelined dividers (key by stored rows, coordinates by
// grid, local indexes by virtual grid) and the result register.
// busy_o stays low: the pipeline flows every cycle and the receiver cannot
// stall. Reset clears valid bits and sets the configuration to its defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sym_block_cyclic_tile_owner_unit
  import sbcto_pkg::*;
#(
  parameter int unsigned TILE_INDEX_BITS = TILE_INDEX_BITS_DEF,
  parameter int unsigned GRID_DIM_BITS   = GRID_DIM_BITS_DEF,
  localparam int unsigned TIB      = TILE_INDEX_BITS,
  localparam int unsigned GLOBAL_W = TILE_INDEX_BITS + 1,
  localparam int unsigned RANK_W   = 2 * GRID_DIM_BITS,
  localparam int unsigned CFG_W    = (TIB > GRID_REG_W) ? TIB : GRID_REG_W
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // command
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 kind_i,
  input  wire logic [TIB-1:0]       tile_row_i,
  input  wire logic [TIB-1:0]       tile_col_i,
  input  wire logic [KEY_W-1:0]     tile_key_i,
  // result
  output logic                      done_o,
  output logic [GLOBAL_W-1:0]       global_row_o,
  output logic [GLOBAL_W-1:0]       global_col_o,
  output logic [RANK_W-1:0]         owner_rank_o,
  output logic                      outside_triangle_o,
  output logic [VP_W-1:0]           vp_index_o
);

  localparam int unsigned DIV_N       = KEY_W;
  localparam int unsigned RANK_MIN_W  = 2 * GRID_REG_W + 1;
  localparam int unsigned RANK_CALC_W = (RANK_W > RANK_MIN_W) ? RANK_W : RANK_MIN_W;
  localparam int unsigned VP_CALC_W   = 2 * VP_REG_W + 1;
  localparam logic [KEY_W-1:0] GLOBAL_MAX = KEY_W'((64'd1 << GLOBAL_W) - 64'd1);

  typedef struct packed {
    logic                kind;
    logic [GLOBAL_W-1:0] gr;
    logic [GLOBAL_W-1:0] gc;
  } line_a_t;

  typedef struct packed {
    logic [GLOBAL_W-1:0] gr;
    logic [GLOBAL_W-1:0] gc_sat;
    logic                outside;
  } line_c_t;

  typedef struct packed {
    line_c_t           pos;
    logic [RANK_W-1:0] rank;
  } line_d_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [GRID_REG_W-1:0] grid_rows_q, grid_cols_q;
  logic [TIB-1:0]        row_off_q, col_off_q, stored_rows_q;
  logic                  triangle_q;
  logic [VP_REG_W-1:0]   vp_rows_q, vp_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q   <= GRID_REG_W'(1);
      grid_cols_q   <= GRID_REG_W'(1);
      row_off_q     <= '0;
      col_off_q     <= '0;
      stored_rows_q <= TIB'(1);
      triangle_q    <= 1'b0;
      vp_rows_q     <= VP_REG_W'(1);
      vp_cols_q     <= VP_REG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_ROWS:   grid_rows_q   <= cfg_data_i[GRID_REG_W-1:0];
        REG_GRID_COLS:   grid_cols_q   <= cfg_data_i[GRID_REG_W-1:0];
        REG_ROW_OFFSET:  row_off_q     <= cfg_data_i[TIB-1:0];
        REG_COL_OFFSET:  col_off_q     <= cfg_data_i[TIB-1:0];
        REG_STORED_ROWS: stored_rows_q <= cfg_data_i[TIB-1:0];
        REG_TRIANGLE:    triangle_q    <= cfg_data_i[0];
        REG_VP_ROWS:     vp_rows_q     <= cfg_data_i[VP_REG_W-1:0];
        REG_VP_COLS:     vp_cols_q     <= cfg_data_i[VP_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero divisors count as one
  logic [GRID_REG_W-1:0] pr_nz, pc_nz;
  logic [TIB-1:0]        lmt_nz;
  logic [VP_REG_W-1:0]   vr_nz, vc_nz;

  assign pr_nz  = (grid_rows_q == '0)   ? GRID_REG_W'(1) : grid_rows_q;
  assign pc_nz  = (grid_cols_q == '0)   ? GRID_REG_W'(1) : grid_cols_q;
  assign lmt_nz = (stored_rows_q == '0) ? TIB'(1)        : stored_rows_q;
  assign vr_nz  = (vp_rows_q == '0)     ? VP_REG_W'(1)   : vp_rows_q;
  assign vc_nz  = (vp_cols_q == '0)     ? VP_REG_W'(1)   : vp_cols_q;

  // pipeline always takes a beat
  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic             s0_valid_q;
  logic             s0_kind_q;
  logic [TIB-1:0]   s0_row_q, s0_col_q;
  logic [KEY_W-1:0] s0_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_kind_q <= kind_i;
    s0_row_q  <= tile_row_i;
    s0_col_q  <= tile_col_i;
    s0_key_q  <= tile_key_i;
  end

  // --------------------------------------------------------------------------
  // key split: key / stored rows, relative coordinates wait alongside
  // --------------------------------------------------------------------------
  logic             d1_valid;
  logic [KEY_W-1:0] d1_quo;
  logic [TIB-1:0]   d1_rem;

  sbcto_div #(
    .N (DIV_N),
    .D (TIB)
  ) u_div_key (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s0_valid_q),
    .dividend_i  (s0_key_q),
    .divisor_i   (lmt_nz),
    .valid_o     (d1_valid),
    .quotient_o  (d1_quo),
    .remainder_o (d1_rem)
  );

  line_a_t line_a_q [DIV_N];

  always_ff @(posedge clk_i) begin
    line_a_q[0].kind <= s0_kind_q;
    line_a_q[0].gr   <= GLOBAL_W'(s0_row_q) + GLOBAL_W'(row_off_q);
    line_a_q[0].gc   <= GLOBAL_W'(s0_col_q) + GLOBAL_W'(col_off_q);
    for (int i = 1; i < DIV_N; i++) begin
      line_a_q[i] <= line_a_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // global coordinates
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  logic [GLOBAL_W-1:0] s1_gr_q;
  logic [KEY_W-1:0]    s1_gc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_gr_q <= line_a_q[DIV_N-1].kind ? GLOBAL_W'(d1_rem) : line_a_q[DIV_N-1].gr;
    s1_gc_q <= line_a_q[DIV_N-1].kind ? d1_quo : KEY_W'(line_a_q[DIV_N-1].gc);
  end

  // triangle test on the full column, column saturated for the result
  line_c_t s1_pos;

  always_comb begin
    s1_pos.gr      = s1_gr_q;
    s1_pos.gc_sat  = (s1_gc_q > GLOBAL_MAX) ? {GLOBAL_W{1'b1}} : s1_gc_q[GLOBAL_W-1:0];
    s1_pos.outside = triangle_q ? (KEY_W'(s1_gr_q) > s1_gc_q)
                                : (KEY_W'(s1_gr_q) < s1_gc_q);
  end

  // --------------------------------------------------------------------------
  // grid split: row / grid rows, column / grid cols
  // --------------------------------------------------------------------------
  logic                  d2_valid;
  logic [DIV_N-1:0]      d2_quo, d3_quo;
  logic [GRID_REG_W-1:0] d2_rem, d3_rem;

  sbcto_div #(
    .N (DIV_N),
    .D (GRID_REG_W)
  ) u_div_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid_q),
    .dividend_i  (KEY_W'(s1_gr_q)),
    .divisor_i   (pr_nz),
    .valid_o     (d2_valid),
    .quotient_o  (d2_quo),
    .remainder_o (d2_rem)
  );

  sbcto_div #(
    .N (DIV_N),
    .D (GRID_REG_W)
  ) u_div_col (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid_q),
    .dividend_i  (s1_gc_q),
    .divisor_i   (pc_nz),
    .valid_o     (),
    .quotient_o  (d3_quo),
    .remainder_o (d3_rem)
  );

  line_c_t line_c_q [DIV_N];

  always_ff @(posedge clk_i) begin
    line_c_q[0] <= s1_pos;
    for (int i = 1; i < DIV_N; i++) begin
      line_c_q[i] <= line_c_q[i-1];
    end
  end

  // owner rank: grid row times grid cols plus grid column
  logic [RANK_CALC_W-1:0] rank_calc;

  assign rank_calc = RANK_CALC_W'(d2_rem) * RANK_CALC_W'(pc_nz) + RANK_CALC_W'(d3_rem);

  // --------------------------------------------------------------------------
  // virtual grid split: local indexes modulo virtual grid
  // --------------------------------------------------------------------------
  logic                d4_valid;
  logic [VP_REG_W-1:0] d4_rem, d5_rem;

  sbcto_div #(
    .N (DIV_N),
    .D (VP_REG_W)
  ) u_div_vrow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (d2_valid),
    .dividend_i  (d2_quo),
    .divisor_i   (vr_nz),
    .valid_o     (d4_valid),
    .quotient_o  (),
    .remainder_o (d4_rem)
  );

  sbcto_div #(
    .N (DIV_N),
    .D (VP_REG_W)
  ) u_div_vcol (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (d2_valid),
    .dividend_i  (d3_quo),
    .divisor_i   (vc_nz),
    .valid_o     (),
    .quotient_o  (),
    .remainder_o (d5_rem)
  );

  line_d_t line_d_q [DIV_N];

  always_ff @(posedge clk_i) begin
    line_d_q[0].pos  <= line_c_q[DIV_N-1];
    line_d_q[0].rank <= rank_calc[RANK_W-1:0];
    for (int i = 1; i < DIV_N; i++) begin
      line_d_q[i] <= line_d_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic [VP_CALC_W-1:0] vp_calc;

  assign vp_calc = VP_CALC_W'(d5_rem) * VP_CALC_W'(vr_nz) + VP_CALC_W'(d4_rem);

  logic                done_q;
  logic [GLOBAL_W-1:0] row_q, col_q;
  logic [RANK_W-1:0]   rank_q;
  logic                outside_q;
  logic [VP_W-1:0]     vp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d4_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= line_d_q[DIV_N-1].pos.gr;
    col_q     <= line_d_q[DIV_N-1].pos.gc_sat;
    outside_q <= line_d_q[DIV_N-1].pos.outside;
    rank_q    <= line_d_q[DIV_N-1].pos.outside ? '0 : line_d_q[DIV_N-1].rank;
    vp_q      <= vp_calc[VP_W-1:0];
  end

  assign done_o             = done_q;
  assign global_row_o       = row_q;
  assign global_col_o       = col_q;
  assign owner_rank_o       = rank_q;
  assign outside_triangle_o = outside_q;
  assign vp_index_o         = vp_q;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for the symmetric block-cyclic tile owner unit
// Drives tile queries, either relative coordinates or linear keys, under a
// series of grid settings. Each accepted beat is run through a local owner
// model and the expected lookup is queued; every done_o beat is checked
// field by field against the oldest queued lookup.
// ----------------------------------------------------------------------------
module tb;
  import sbcto_pkg::*;

  localparam int unsigned TIB      = TILE_INDEX_BITS_DEF;
  localparam int unsigned GLOBAL_W = TILE_INDEX_BITS_DEF + 1;
  localparam int unsigned RANK_W   = 2 * GRID_DIM_BITS_DEF;
  localparam int unsigned CFG_W    = (TIB > GRID_REG_W) ? TIB : GRID_REG_W;
  localparam int unsigned LATENCY  = 99;
  localparam int unsigned LIMIT    = 400000;

  typedef struct packed {
    logic [GLOBAL_W-1:0] global_row;
    logic [GLOBAL_W-1:0] global_col;
    logic [RANK_W-1:0]   owner_rank;
    logic                outside;
    logic [VP_W-1:0]     vp_index;
  } owner_res_t;

  // DUT signals
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 start_i;
  logic                 busy_o;
  logic                 kind_i;
  logic [TIB-1:0]       tile_row_i;
  logic [TIB-1:0]       tile_col_i;
  logic [KEY_W-1:0]     tile_key_i;
  logic                 done_o;
  logic [GLOBAL_W-1:0]  global_row_o;
  logic [GLOBAL_W-1:0]  global_col_o;
  logic [RANK_W-1:0]    owner_rank_o;
  logic                 outside_triangle_o;
  logic [VP_W-1:0]      vp_index_o;

  // model copy of the configuration registers
  logic [GRID_REG_W-1:0] m_grid_rows;
  logic [GRID_REG_W-1:0] m_grid_cols;
  logic [TIB-1:0]        m_row_off;
  logic [TIB-1:0]        m_col_off;
  logic [TIB-1:0]        m_stored_rows;
  logic                  m_triangle;
  logic [VP_REG_W-1:0]   m_vp_rows;
  logic [VP_REG_W-1:0]   m_vp_cols;

  owner_res_t  pending_owners[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned burst_left;

  sym_block_cyclic_tile_owner_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .kind_i             (kind_i),
    .tile_row_i         (tile_row_i),
    .tile_col_i         (tile_col_i),
    .tile_key_i         (tile_key_i),
    .done_o             (done_o),
    .global_row_o       (global_row_o),
    .global_col_o       (global_col_o),
    .owner_rank_o       (owner_rank_o),
    .outside_triangle_o (outside_triangle_o),
    .vp_index_o         (vp_index_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // owner model
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] at_least_one(logic [63:0] v);
    return (v == 64'd0) ? 64'd1 : v;
  endfunction

  function automatic owner_res_t predict_owner(logic kind, logic [TIB-1:0] row,
                                               logic [TIB-1:0] col,
                                               logic [KEY_W-1:0] key);
    logic [63:0] gr, gc, pr, pc, vr, vc, divisor, rank, vp;
    logic        outside;
    owner_res_t  res;
    pr = at_least_one(64'(m_grid_rows));
    pc = at_least_one(64'(m_grid_cols));
    vr = at_least_one(64'(m_vp_rows));
    vc = at_least_one(64'(m_vp_cols));
    if (!kind) begin
      gr = 64'(row) + 64'(m_row_off);
      gc = 64'(col) + 64'(m_col_off);
    end else begin
      divisor = at_least_one(64'(m_stored_rows));
      gr = 64'(key) % divisor;
      gc = 64'(key) / divisor;
    end
    outside = m_triangle ? (gr > gc) : (gr < gc);
    rank = (gr % pr) * pc + (gc % pc);
    vp   = ((gc / pc) % vc) * vr + ((gr / pr) % vr);
    res.global_row = gr[GLOBAL_W-1:0];
    // quotient of a large key saturates the column field
    res.global_col = (gc > {{(64-GLOBAL_W){1'b0}}, {GLOBAL_W{1'b1}}}) ?
                     {GLOBAL_W{1'b1}} : gc[GLOBAL_W-1:0];
    res.owner_rank = outside ? '0 : rank[RANK_W-1:0];
    res.outside    = outside;
    res.vp_index   = vp[VP_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    owner_res_t exp_res;
    if (rst_ni) begin
      if ($isunknown(done_o)) begin
        $error("done_o: expected known value, actual %b", done_o);
        fail_count++;
      end else if (done_o) begin
        if (pending_owners.size() == 0) begin
          $error("done_o: result beat with no lookup pending");
          fail_count++;
        end else begin
          exp_res = pending_owners.pop_front();
          if (global_row_o !== exp_res.global_row) begin
            $error("global_row: expected %0d, actual %0d", exp_res.global_row,
                   global_row_o);
            fail_count++;
          end
          if (global_col_o !== exp_res.global_col) begin
            $error("global_col: expected %0d, actual %0d", exp_res.global_col,
                   global_col_o);
            fail_count++;
          end
          if (owner_rank_o !== exp_res.owner_rank) begin
            $error("owner_rank: expected %0d, actual %0d", exp_res.owner_rank,
                   owner_rank_o);
            fail_count++;
          end
          if (outside_triangle_o !== exp_res.outside) begin
            $error("outside_triangle: expected %0d, actual %0d", exp_res.outside,
                   outside_triangle_o);
            fail_count++;
          end
          if (vp_index_o !== exp_res.vp_index) begin
            $error("vp_index: expected %0d, actual %0d", exp_res.vp_index,
                   vp_index_o);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // idle fields carry noise, the block must ignore them
  task automatic scramble_fields();
    kind_i     = 1'($urandom);
    tile_row_i = TIB'($urandom);
    tile_col_i = TIB'($urandom);
    tile_key_i = $urandom;
  endtask

  // one command beat, then gap idle cycles
  task automatic send_tile(logic kind, logic [TIB-1:0] row, logic [TIB-1:0] col,
                           logic [KEY_W-1:0] key, int unsigned gap);
    @(negedge clk_i);
    start_i    = 1'b1;
    kind_i     = kind;
    tile_row_i = row;
    tile_col_i = col;
    tile_key_i = key;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_owners.push_back(predict_owner(kind, row, col, key));
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      scramble_fields();
      repeat (gap - 1) begin
        @(negedge clk_i);
        scramble_fields();
      end
    end
  endtask

  // stop issuing and let every pending lookup come back
  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_owners.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      REG_GRID_ROWS:   m_grid_rows   = data[GRID_REG_W-1:0];
      REG_GRID_COLS:   m_grid_cols   = data[GRID_REG_W-1:0];
      REG_ROW_OFFSET:  m_row_off     = data[TIB-1:0];
      REG_COL_OFFSET:  m_col_off     = data[TIB-1:0];
      REG_STORED_ROWS: m_stored_rows = data[TIB-1:0];
      REG_TRIANGLE:    m_triangle    = data[0];
      REG_VP_ROWS:     m_vp_rows     = data[VP_REG_W-1:0];
      REG_VP_COLS:     m_vp_cols     = data[VP_REG_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_data_i = CFG_W'($urandom);
  endtask

  task automatic write_all_regs(logic [CFG_W-1:0] g_rows, logic [CFG_W-1:0] g_cols,
                                logic [CFG_W-1:0] r_off, logic [CFG_W-1:0] c_off,
                                logic [CFG_W-1:0] s_rows, logic [CFG_W-1:0] tri_sel,
                                logic [CFG_W-1:0] v_rows, logic [CFG_W-1:0] v_cols);
    write_reg(REG_GRID_ROWS, g_rows);
    write_reg(REG_GRID_COLS, g_cols);
    write_reg(REG_ROW_OFFSET, r_off);
    write_reg(REG_COL_OFFSET, c_off);
    write_reg(REG_STORED_ROWS, s_rows);
    write_reg(REG_TRIANGLE, tri_sel);
    write_reg(REG_VP_ROWS, v_rows);
    write_reg(REG_VP_COLS, v_cols);
  endtask

  // mostly back to back or short, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] pick_grid_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 6)  return CFG_W'($urandom_range(1, 8));
    if (r < 8)  return CFG_W'($urandom_range(1, 4096));
    if (r == 8) return CFG_W'(4096);
    return CFG_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_vp_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 6)  return CFG_W'($urandom_range(1, 6));
    if (r < 8)  return CFG_W'($urandom_range(1, 256));
    if (r == 8) return CFG_W'(256);
    return CFG_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_tile_reg(bit allow_zero);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return allow_zero ? '0 : CFG_W'(1);
    if (r < 5)  return CFG_W'($urandom_range(1, 64));
    if (r == 5) return '1;
    return CFG_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // defaults after reset: unit grid, no offsets, lower half stored
  task automatic test_reset_defaults();
    send_tile(1'b0, '0, '0, '0, 0);
    send_tile(1'b0, '1, '1, '0, 1);
    send_tile(1'b0, TIB'(0), TIB'(1), '0, 0);
    send_tile(1'b1, '0, '0, 32'd0, 2);
    send_tile(1'b1, '0, '0, 32'hFFFF_FFFF, 0);
    wait_drained();
  endtask

  // maximal offsets, upper half stored, field extremes of both forms
  task automatic test_field_extremes();
    write_all_regs(16'd3, 16'd5, 16'hFFFF, 16'hFFFF, 16'd7, 16'd1, 16'd4, 16'd3);
    send_tile(1'b0, '0, '0, '0, 0);
    send_tile(1'b0, '1, '0, '0, 0);
    send_tile(1'b0, '0, '1, '0, 3);
    send_tile(1'b1, '1, '1, 32'hFFFF_FFFF, 0);
    send_tile(1'b1, '0, '0, 32'd48, 0);
    wait_drained();
  endtask

  // zero in every divisor register acts as one
  task automatic test_zero_divisors();
    write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_tile(1'b1, '0, '0, 32'd123456, 0);
    send_tile(1'b0, TIB'(5), TIB'(3), '0, 0);
    wait_drained();
  endtask

  // register values above their range, rank wraps to its width
  task automatic test_beyond_range();
    write_all_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFE, 16'hFFFF,
                   16'hFFFF);
    send_tile(1'b0, TIB'(8190), TIB'(8190), '0, 0);
    send_tile(1'b1, '0, '0, 32'hFFFF_FFFF, 1);
    send_tile(1'b1, '0, '0, 32'hFFFE_FFFE, 0);
    wait_drained();
  endtask

  // large virtual grid on a unit process grid, vp_index wraps
  task automatic test_vp_wrap();
    write_all_regs(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd511, 16'd511);
    send_tile(1'b0, TIB'(510), TIB'(510), '0, 0);
    send_tile(1'b0, TIB'(1000), TIB'(900), '0, 0);
    wait_drained();
  endtask

  // random configurations, each followed by a run of random lookups
  task automatic test_random_lookups(int unsigned phases, int unsigned per_phase);
    logic [KEY_W-1:0] key;
    logic [63:0]      divisor;
    logic [63:0]      lin;
    logic [TIB-1:0]   row;
    logic [TIB-1:0]   col;
    logic             kind;
    for (int p = 0; p < phases; p++) begin
      if (p == 0)
        // upper ends of every documented range
        write_all_regs(16'd4096, 16'd4096, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1,
                       16'd256, 16'd256);
      else if (p == 1)
        // lower ends
        write_all_regs(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1);
      else
        write_all_regs(pick_grid_dim(), pick_grid_dim(), pick_tile_reg(1'b1),
                       pick_tile_reg(1'b1), pick_tile_reg(1'b1), CFG_W'($urandom),
                       pick_vp_dim(), pick_vp_dim());
      for (int n = 0; n < per_phase; n++) begin
        kind = 1'($urandom);
        row  = TIB'($urandom);
        col  = TIB'($urandom);
        key  = $urandom;
        if (!kind) begin
          // small coordinates land near the diagonal
          if ($urandom_range(0, 2) == 0) begin
            row = TIB'($urandom_range(0, 63));
            col = TIB'($urandom_range(0, 63));
          end
        end else if ($urandom_range(0, 4) < 3) begin
          // well-formed key: column times stored rows plus row
          divisor = at_least_one(64'(m_stored_rows));
          lin = 64'($urandom_range(0, 32'(divisor) + 3)) * divisor +
                64'($urandom) % divisor;
          key = lin[KEY_W-1:0];
        end
        send_tile(kind, row, col, key, pick_gap());
      end
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count    = 0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    start_i       = 1'b0;
    kind_i        = 1'b0;
    tile_row_i    = '0;
    tile_col_i    = '0;
    tile_key_i    = '0;
    m_grid_rows   = GRID_REG_W'(1);
    m_grid_cols   = GRID_REG_W'(1);
    m_row_off     = '0;
    m_col_off     = '0;
    m_stored_rows = TIB'(1);
    m_triangle    = 1'b0;
    m_vp_rows     = VP_REG_W'(1);
    m_vp_cols     = VP_REG_W'(1);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_zero_divisors();
    test_beyond_range();
    test_vp_wrap();
    test_random_lookups(7, 100);

    // catch any stray result beat after the last lookup
    repeat (LATENCY + 20) @(posedge clk_i);
    if (fail_count == 0 && pending_owners.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
